@@ src/cel_pkg.sv @@
// cel_pkg: shared types and constants of the compacting element list
// command and result item structs, command and status codes, controller states
// no dependencies
`default_nettype none

package cel_pkg;

    // default sizes of the list
    localparam int DEPTH_DEF      = 32;
    localparam int ELEM_WIDTH_DEF = 32;

    // command codes
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_SEARCH = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOR  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // command item
    typedef struct packed {
        logic [2:0]         op;
        logic [5:0]         index;
        logic signed [31:0] value;
    } t_in;

    // result item
    typedef struct packed {
        logic signed [31:0] read_value;
        logic               hit;
        logic [4:0]         hit_index;
        logic [1:0]         status;
        logic [5:0]         used_count;
    } t_out;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_SEARCH
    } t_state;

endpackage

`default_nettype wire

@@ src/compacting_element_list.sv @@
// compacting_element_list: bounded ordered list of signed words in one memory
// append, read, write, remove with compaction, and linear search
// depends on cel_pkg
//
//  channel | direction | signals                              | payload
//  --------+-----------+--------------------------------------+---------------
//  command | in        | i_in_valid, o_in_ready, i_in_data    | cel_pkg::t_in
//  result  | out       | o_out_valid, i_out_ready, o_out_data | cel_pkg::t_out
//
// one item at a time; the memory (one read port, one write port) sets the
// pace. a command reads its first entry when taken; a search then reads
// entries in order up to a hit or the end, a remove below the last entry
// moves the tail down one entry at a time, and all others finish in exec.
// a finished result waits in the output register; the next item is taken
// while it waits, and a later item only finishes once that register is free.
// reset clears the count and the control state; the memory is not cleared.
`default_nettype none

module compacting_element_list #(
    parameter int DEPTH      = cel_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = cel_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire cel_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output cel_pkg::t_out      o_out_data
);
    import cel_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (AW > 6) ? AW : 6;
    localparam int XW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // element memory
    logic [ELEM_WIDTH-1:0] mem [DEPTH];
    logic [ELEM_WIDTH-1:0] r_rdata;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;

    // control and command registers
    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_ptr, n_ptr;
    logic [2:0]            r_op;
    logic [5:0]            r_idx;
    logic [ELEM_WIDTH-1:0] r_val;
    logic [ELEM_WIDTH-1:0] r_rem, n_rem;
    logic                  r_out_valid;
    t_out                  r_out_data;

    // decoded conditions
    logic                  accept;
    logic                  out_free;
    logic                  done;
    logic                  go_shift;
    t_out                  res;
    logic [ELEM_WIDTH-1:0] res_elem;
    logic                  idx_oob;
    logic [CW-1:0]         idx_c;
    logic [CW-1:0]         idx_p1;
    logic [CW-1:0]         ptr_m2;
    logic [IW-1:0]         in_idx_ext;
    logic [IW-1:0]         r_idx_ext;
    logic [63:0]           in_val_ext;
    logic [63:0]           res_ext;
    logic [15:0]           cnt_ext;
    logic [15:0]           ptr_ext;

    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_idx_ext = IW'(i_in_data.index);
    assign r_idx_ext  = IW'(r_idx);
    assign in_val_ext = 64'(i_in_data.value);
    assign idx_oob    = (XW'(r_idx) >= XW'(r_count));
    assign idx_c      = CW'(r_idx);
    assign idx_p1     = idx_c + 1'b1;
    assign ptr_m2     = r_ptr - CW'(2);
    assign cnt_ext    = 16'(n_count);
    assign ptr_ext    = 16'(r_ptr);

    // memory access: registered read, one write a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in_data.op == OP_SEARCH) ? S_SEARCH : S_EXEC;
                end
            end
            S_EXEC: begin
                if (go_shift) begin
                    n_state = S_SHIFT;
                end else if (done) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT, S_SEARCH: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control and result
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = r_ptr[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_idx_ext[AW-1:0];
        wr_data   = r_val;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_rem     = r_rem;
        done      = 1'b0;
        go_shift  = 1'b0;
        res_elem  = '0;
        res.hit        = 1'b0;
        res.hit_index  = '0;
        res.status     = ST_OK;
        case (r_state)
            S_IDLE: begin
                // start the read that the command needs first
                if (accept) begin
                    rd_en = 1'b1;
                    if (i_in_data.op == OP_SEARCH) begin
                        rd_addr   = '0;
                        n_ptr     = '0;
                    end else begin
                        rd_addr = in_idx_ext[AW-1:0];
                    end
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_APPEND: begin
                        if (r_count == DEPTH_C) begin
                            res.status = ST_FULL;
                        end else begin
                            wr_en   = out_free;
                            wr_addr = r_count[AW-1:0];
                            n_count = out_free ? r_count + 1'b1 : r_count;
                        end
                        done = out_free;
                    end
                    OP_READ: begin
                        if (idx_oob) begin
                            res.status = ST_OOR;
                        end else begin
                            res_elem = r_rdata;
                        end
                        done = out_free;
                    end
                    OP_WRITE: begin
                        if (idx_oob) begin
                            res.status = ST_OOR;
                        end else begin
                            wr_en = out_free;
                        end
                        done = out_free;
                    end
                    OP_REMOVE: begin
                        if (idx_oob) begin
                            res.status = ST_OOR;
                            done       = out_free;
                        end else if (idx_p1 < r_count) begin
                            // removed value captured, start moving the tail down
                            n_rem    = r_rdata;
                            rd_en    = 1'b1;
                            rd_addr  = idx_p1[AW-1:0];
                            n_ptr    = idx_p1 + 1'b1;
                            go_shift = 1'b1;
                        end else begin
                            res_elem = r_rdata;
                            n_count  = out_free ? r_count - 1'b1 : r_count;
                            done     = out_free;
                        end
                    end
                    default: begin
                        done = out_free;
                    end
                endcase
            end
            S_SHIFT: begin
                // r_rdata holds entry ptr-1, it moves to ptr-2
                wr_en    = 1'b1;
                wr_addr  = ptr_m2[AW-1:0];
                wr_data  = r_rdata;
                res_elem = r_rem;
                if (r_ptr < r_count) begin
                    rd_en = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                end else begin
                    n_count = out_free ? r_count - 1'b1 : r_count;
                    done    = out_free;
                end
            end
            S_SEARCH: begin
                // r_rdata holds entry ptr
                if (r_ptr >= r_count) begin
                    done = out_free;
                end else if (r_rdata == r_val) begin
                    res.hit       = 1'b1;
                    res.hit_index = ptr_ext[4:0];
                    done          = out_free;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = CW'(r_ptr + 1'b1) < DEPTH_C ?
                              AW'(r_ptr + 1'b1) : '0;
                    n_ptr   = r_ptr + 1'b1;
                end
            end
            default: begin
            end
        endcase
        res_ext        = 64'($signed(res_elem));
        res.read_value = res_ext[31:0];
        res.used_count = cnt_ext[5:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command, pointer and result registers
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_rem <= n_rem;
        if (accept) begin
            r_op  <= i_in_data.op;
            r_idx <= i_in_data.index;
            r_val <= in_val_ext[ELEM_WIDTH-1:0];
        end
        if (done) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// tb: self-checking testbench of compacting_element_list, directed table then random commands
// results checked field by field against typed-in values or an in-bench model of the list
// depends on cel_pkg and compacting_element_list
`timescale 1ns / 1ps

module tb;
    import cel_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 800;
    localparam int IDLE_PCT     = 23;
    localparam int DRAIN_CYCLES = 40;

    // commands the block ignores
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    localparam t_out UNCHECKED = '0;

    typedef struct {
        t_in  cmd;
        bit   known;
        t_out want;
    } t_row;

    typedef enum int {EP_FILL, EP_DRAIN, EP_MIX} t_episode;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // model of the list
    logic signed [31:0] list_mem [LIST_DEPTH];
    int                 list_len = 0;

    t_out pending_results [$];
    int   fault_count = 0;
    bit   steady      = 1'b0;

    // directed commands; want typed in where the answer is plain
    t_row directed_rows [N_DIRECTED] = '{
        '{'{OP_READ,   6'd0,  32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OOR, 6'd0}},
        '{'{OP_REMOVE, 6'd63, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OOR, 6'd0}},
        '{'{OP_WRITE,  6'd0,  32'sd1}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OOR, 6'd0}},
        '{'{OP_SEARCH, 6'd0,  32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK, 6'd0}},
        '{'{OP_SPARE_LO, 6'd0, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK, 6'd0}},
        '{'{OP_APPEND, 6'd0,  32'h7FFFFFFF}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK, 6'd1}},
        '{'{OP_APPEND, 6'd0,  32'h80000000}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK, 6'd2}},
        '{'{OP_APPEND, 6'd0,  32'hFFFFFFFF}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK, 6'd3}},
        '{'{OP_APPEND, 6'd0,  32'h00000000}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK, 6'd4}},
        '{'{OP_APPEND, 6'd0,  32'hFFFFFFFF}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK, 6'd5}},
        '{'{OP_READ,   6'd1,  32'sd0}, 1'b1, '{32'h80000000, 1'b0, 5'd0, ST_OK, 6'd5}},
        '{'{OP_READ,   6'd0,  32'sd0}, 1'b1, '{32'h7FFFFFFF, 1'b0, 5'd0, ST_OK, 6'd5}},
        '{'{OP_SEARCH, 6'd0,  32'hFFFFFFFF}, 1'b1, '{32'sd0, 1'b1, 5'd2, ST_OK, 6'd5}},
        '{'{OP_SEARCH, 6'd0,  32'd12345}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK, 6'd5}},
        '{'{OP_WRITE,  6'd2,  32'h55AA55AA}, 1'b0, UNCHECKED},
        '{'{OP_SEARCH, 6'd0,  32'hFFFFFFFF}, 1'b0, UNCHECKED},
        '{'{OP_READ,   6'd5,  32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OOR, 6'd5}},
        '{'{OP_WRITE,  6'd63, 32'sd7}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OOR, 6'd5}},
        '{'{OP_REMOVE, 6'd0,  32'sd0}, 1'b1, '{32'h7FFFFFFF, 1'b0, 5'd0, ST_OK, 6'd4}},
        '{'{OP_READ,   6'd0,  32'sd0}, 1'b0, UNCHECKED},
        '{'{OP_REMOVE, 6'd3,  32'sd0}, 1'b0, UNCHECKED},
        '{'{OP_SPARE_HI, 6'd63, 32'hFFFFFFFF}, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK, 6'd3}},
        '{'{OP_SEARCH, 6'd0,  32'sd0}, 1'b0, UNCHECKED},
        '{'{OP_SPARE_MID, 6'd63, 32'hFFFFFFFF}, 1'b0, UNCHECKED},
        '{'{OP_REMOVE, 6'd1,  32'sd0}, 1'b0, UNCHECKED}
    };

    compacting_element_list uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // apply one command to the model list and return its result item
    function automatic t_out next_list_result(t_in cmd);
        t_out res;
        int   j;
        res = '0;
        case (cmd.op)
            OP_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_mem[list_len] = cmd.value;
                    list_len++;
                end
            end
            OP_READ: begin
                if (cmd.index >= list_len) res.status = ST_OOR;
                else res.read_value = list_mem[cmd.index];
            end
            OP_WRITE: begin
                if (cmd.index >= list_len) res.status = ST_OOR;
                else list_mem[cmd.index] = cmd.value;
            end
            OP_REMOVE: begin
                if (cmd.index >= list_len) begin
                    res.status = ST_OOR;
                end else begin
                    res.read_value = list_mem[cmd.index];
                    for (j = int'(cmd.index); j + 1 < list_len; j++)
                        list_mem[j] = list_mem[j + 1];
                    list_len--;
                end
            end
            OP_SEARCH: begin
                for (j = 0; j < list_len; j++) begin
                    if (list_mem[j] == cmd.value) begin
                        res.hit       = 1'b1;
                        res.hit_index = j[4:0];
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.used_count = list_len[5:0];
        return res;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fault_count++;
        end
    endfunction

    // offer one command item, with random gaps ahead of it
    task automatic send_command(input t_in cmd, input bit known, input t_out want);
        t_out predicted;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = next_list_result(cmd);
        pending_results.insert(pending_results.size(), known ? want : predicted);
    endtask

    // result side back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no command pending");
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("read_value", want.read_value, o_out_data.read_value);
                compare_field("hit", want.hit, o_out_data.hit);
                compare_field("hit_index", want.hit_index, o_out_data.hit_index);
                compare_field("status", want.status, o_out_data.status);
                compare_field("used_count", want.used_count, o_out_data.used_count);
            end
        end
    end

    // stimulus
    initial begin
        int       n_sent;
        int       ep_len;
        int       pick;
        int       add_pct;
        int       del_pct;
        t_episode ep;
        t_in      cmd;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_command(directed_rows[k].cmd, directed_rows[k].known, directed_rows[k].want);

        // random episodes; the first one fills the list past full
        n_sent = 0;
        ep     = EP_FILL;
        ep_len = 70;
        while (n_sent < N_RANDOM) begin
            steady = (n_sent >= 300 && n_sent < 450);
            if (ep_len == 0) begin
                ep     = t_episode'($urandom_range(2));
                ep_len = $urandom_range(20, 60);
            end
            ep_len--;
            case (ep)
                EP_FILL:  begin add_pct = 60; del_pct = 8;  end
                EP_DRAIN: begin add_pct = 10; del_pct = 45; end
                default:  begin add_pct = 25; del_pct = 20; end
            endcase

            // command code
            pick = $urandom_range(99);
            if (pick < 3) begin
                cmd.op = 3'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI)));
            end else if (pick < 3 + add_pct) begin
                cmd.op = OP_APPEND;
            end else if (pick < 3 + add_pct + del_pct) begin
                cmd.op = OP_REMOVE;
            end else begin
                case ($urandom_range(2))
                    0:       cmd.op = OP_READ;
                    1:       cmd.op = OP_WRITE;
                    default: cmd.op = OP_SEARCH;
                endcase
            end

            // mostly valid positions, sometimes anywhere
            if (list_len > 0 && $urandom_range(99) < 85)
                cmd.index = 6'($urandom_range(list_len - 1));
            else
                cmd.index = 6'($urandom_range(63));

            // small values give duplicates, copies give search hits
            pick = $urandom_range(99);
            if (pick < 30)
                cmd.value = 32'(int'($urandom_range(4)) - 2);
            else if (pick < 55 && list_len > 0)
                cmd.value = list_mem[$urandom_range(list_len - 1)];
            else
                cmd.value = $urandom;

            send_command(cmd, 1'b0, UNCHECKED);
            if (cmd.op < OP_SPARE_LO)
                n_sent++;
        end
        steady = 1'b0;

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0)
            $display("compacting_element_list regression: pass");
        else
            $display("compacting_element_list regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("compacting_element_list regression: fail");
        $finish;
    end

endmodule
